[rtl/core/xbr_pkg.sv]
// ----------------------------------------------------------------------------
// XMODEM block receiver package
// Shared constants, result record and queue entry types, and the CRC step function.
// ----------------------------------------------------------------------------
package xbr_pkg;

   localparam int LONG_BLOCK_BYTES  = 1024;
   localparam int SHORT_BLOCK_BYTES = 128;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_BYTE  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   localparam logic [7:0] CH_SOH      = 8'h01;
   localparam logic [7:0] CH_STX      = 8'h02;
   localparam logic [7:0] CH_EOT      = 8'h04;
   localparam logic [7:0] CH_ACK      = 8'h06;
   localparam logic [7:0] CH_NAK      = 8'h15;
   localparam logic [7:0] CH_CAN      = 8'h18;
   localparam logic [7:0] CH_WANT_CRC = 8'h43;

   localparam logic [7:0] FIRST_WAIT = 8'd130;
   localparam logic [7:0] LATER_WAIT = 8'd70;
   localparam logic [7:0] RETRY_WAIT = 8'd40;
   localparam logic [7:0] CHAR_WAIT  = 8'd50;
   localparam logic [7:0] QUIET_WAIT = 8'd2;
   localparam logic [3:0] CAN_BURST  = 4'd10;

   localparam logic [2:0] ST_RUN    = 3'd0;
   localparam logic [2:0] ST_DONE   = 3'd1;
   localparam logic [2:0] ST_CANCEL = 3'd2;
   localparam logic [2:0] ST_RETRY  = 3'd3;
   localparam logic [2:0] ST_SYNC   = 3'd4;

   localparam int ADDR_W = 4;
   localparam logic [ADDR_W-1:0] REG_CRC_MODE    = 4'd0;
   localparam logic [ADDR_W-1:0] REG_SEVEN_BIT   = 4'd4;
   localparam logic [ADDR_W-1:0] REG_RETRY_LIMIT = 4'd8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   // one result record
   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_char;
      logic       data_valid;
      logic [7:0] data_byte;
      logic       block_commit;
      logic       block_discard;
   } result_type;

   // one queue entry: up to two ordinary results, or a CAN burst
   typedef struct packed {
      logic       can_burst;
      logic [1:0] count;
      result_type r0;
      result_type r1;
      logic [2:0] status;
   } entry_type;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      end
      return c;
   endfunction

endpackage

[rtl/core/xmodem_block_receiver_top.sv]
// ----------------------------------------------------------------------------
// XMODEM block receiver
// Channel   Direction  Handshake
// req_      in         req_valid / req_ready
// rsp_      out        rsp_valid / rsp_ready
// csr_      in/out     APB write/read, pready tied high
// One item per cycle is accepted while the entry queue has room.
// Each item yields up to two results (ten for a CAN burst), one per cycle while rsp_ready is high.
// Synchronous active-high reset; no clearing pass.
// Result stalls back up through the four-entry queue to req_ready.
// ----------------------------------------------------------------------------
module xmodem_block_receiver_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_cmd,
   input  logic [7:0]                  req_line_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_send_valid,
   output logic [7:0]                  rsp_send_char,
   output logic                        rsp_data_valid,
   output logic [7:0]                  rsp_data_byte,
   output logic                        rsp_block_commit,
   output logic                        rsp_block_discard,
   output logic [2:0]                  rsp_status,
   output logic                        rsp_last,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [xbr_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import xbr_pkg::*;

   logic       crc_mode_ff, seven_ff;
   logic [4:0] rlim_ff;
   logic       fe_valid, fe_ready, be_valid, be_ready;
   entry_type  fe_ent, be_ent;
   result_type res;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_mode_ff <= 1'b1; seven_ff <= 1'b0; rlim_ff <= 5'd10;
      end else if (psel && penable && pwrite) begin
         if (paddr == REG_CRC_MODE)    crc_mode_ff <= pwdata[0];
         if (paddr == REG_SEVEN_BIT)   seven_ff    <= pwdata[0];
         if (paddr == REG_RETRY_LIMIT) rlim_ff     <= pwdata[4:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == REG_CRC_MODE)    prdata = {31'd0, crc_mode_ff};
      if (paddr == REG_SEVEN_BIT)   prdata = {31'd0, seven_ff};
      if (paddr == REG_RETRY_LIMIT) prdata = {27'd0, rlim_ff};
   end

   xbr_front u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready),
      .cmd(req_cmd), .line_byte(req_line_byte),
      .crc_mode(crc_mode_ff), .seven_bit_mode(seven_ff), .retry_limit(rlim_ff),
      .ent_valid(fe_valid), .ent(fe_ent), .ent_ready(fe_ready)
   );

   xbr_queue u_queue (
      .clock, .reset,
      .wr_valid(fe_valid), .wr_data(fe_ent), .wr_ready(fe_ready),
      .rd_valid(be_valid), .rd_data(be_ent), .rd_ready(be_ready)
   );

   xbr_back u_back (
      .clock, .reset,
      .ent_valid(be_valid), .ent(be_ent), .ent_ready(be_ready),
      .out_valid(rsp_valid), .out_res(res), .out_status(rsp_status),
      .out_last(rsp_last), .out_ready(rsp_ready)
   );

   assign rsp_send_valid    = res.send_valid;
   assign rsp_send_char     = res.send_char;
   assign rsp_data_valid    = res.data_valid;
   assign rsp_data_byte     = res.data_byte;
   assign rsp_block_commit  = res.block_commit;
   assign rsp_block_discard = res.block_discard;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped under stall");
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_send_valid, rsp_data_valid, rsp_block_discard}) <= 1)
      else $error("mixed result kinds");
   a_commit_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_commit |-> rsp_send_valid && rsp_send_char == CH_ACK)
      else $error("commit without ACK");

endmodule

[rtl/core/xbr_front.sv]
// ----------------------------------------------------------------------------
// XMODEM receiver front end
// Protocol state machine: classifies each item and builds its results entry.
// ----------------------------------------------------------------------------
module xbr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [1:0]          cmd,
   input  logic [7:0]          line_byte,
   input  logic                crc_mode,
   input  logic                seven_bit_mode,
   input  logic [4:0]          retry_limit,
   output logic                ent_valid,
   output xbr_pkg::entry_type  ent,
   input  logic                ent_ready
);
   import xbr_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_HEADER, PH_NUMBER, PH_COMPLEMENT, PH_DATA,
      PH_CHECK_A, PH_CHECK_B, PH_EOT, PH_DRAIN
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        long_ff, long_in;
   logic [7:0]  hnum_ff, hnum_in;
   logic [10:0] bcnt_ff, bcnt_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  expn_ff, expn_in;
   logic        lcan_ff, lcan_in;
   logic [4:0]  ecnt_ff, ecnt_in;
   logic        first_ff, first_in;
   logic [7:0]  tick_ff, tick_in;
   logic [7:0]  wlim_ff, wlim_in;
   logic [7:0]  reply_ff, reply_in;
   logic        crcchk_ff, crcchk_in;
   logic        pass_ff, pass_in;

   logic [7:0]  mask;
   logic [4:0]  rlim;
   logic [7:0]  lim;
   logic [7:0]  tick_nx;
   logic [15:0] crc_nx;
   logic [10:0] bcnt_nx;
   logic [4:0]  ecnt_nx;
   entry_type   e;
   logic        fire;

   assign in_ready  = ent_ready;
   assign fire      = in_valid & in_ready;
   assign mask      = seven_bit_mode ? 8'h7F : 8'hFF;
   assign rlim      = (retry_limit == 5'd0) ? 5'd1 : retry_limit;
   assign crc_nx    = crc_step(crc_ff, line_byte);
   assign tick_nx   = tick_ff + 8'd1;
   assign bcnt_nx   = bcnt_ff + 11'd1;
   assign ecnt_nx   = ecnt_ff + 5'd1;

   always_comb begin
      phase_in = phase_ff; long_in = long_ff; hnum_in = hnum_ff; bcnt_in = bcnt_ff;
      crc_in = crc_ff; sum_in = sum_ff; expn_in = expn_ff; lcan_in = lcan_ff;
      ecnt_in = ecnt_ff; first_in = first_ff; tick_in = tick_ff; wlim_in = wlim_ff;
      reply_in = reply_ff; crcchk_in = crcchk_ff; pass_in = pass_ff;
      e = '0;
      lim = CHAR_WAIT;

      case (cmd)
         CMD_START: begin
            if (pass_ff && bcnt_ff != 11'd0 && (phase_ff == PH_DATA ||
                phase_ff == PH_CHECK_A || phase_ff == PH_CHECK_B)) begin
               e.count = 2'd1;
               e.r0.block_discard = 1'b1;
            end
            expn_in = 8'd0; first_in = 1'b1; bcnt_in = 11'd0;
            crcchk_in = crc_mode;
            reply_in = crc_mode ? CH_WANT_CRC : CH_NAK;
            ecnt_in = '0; lcan_in = 1'b0; pass_in = 1'b0;
            wlim_in = FIRST_WAIT;
            if (e.count == 2'd1) begin
               e.r1.send_valid = 1'b1; e.r1.send_char = reply_in;
            end else begin
               e.r0.send_valid = 1'b1; e.r0.send_char = reply_in;
            end
            e.count = e.count + 2'd1;
            phase_in = PH_HEADER; tick_in = '0;
         end
         CMD_BYTE: begin
            unique case (phase_ff)
               PH_HEADER: begin
                  if (line_byte == CH_STX || line_byte == CH_SOH) begin
                     long_in = (line_byte == CH_STX); phase_in = PH_NUMBER; tick_in = '0;
                  end else if (line_byte == CH_EOT) begin
                     phase_in = PH_EOT; tick_in = '0;
                  end else if (line_byte == CH_CAN) begin
                     if (lcan_ff) begin
                        e.count = 2'd1; e.status = ST_CANCEL;
                        phase_in = PH_IDLE; pass_in = 1'b0;
                     end else begin
                        lcan_in = 1'b1;
                        ecnt_in = ecnt_nx;
                        if (ecnt_nx >= rlim) begin
                           e.can_burst = 1'b1; e.status = ST_RETRY;
                           phase_in = PH_IDLE; pass_in = 1'b0;
                        end else begin
                           e.count = 2'd1;
                           e.r0.send_valid = 1'b1; e.r0.send_char = reply_ff;
                           phase_in = PH_HEADER; tick_in = '0;
                        end
                     end
                  end else begin
                     if (pass_ff && bcnt_ff != 11'd0) begin
                        e.count = 2'd1; e.r0.block_discard = 1'b1;
                     end
                     pass_in = 1'b0; lcan_in = 1'b0; phase_in = PH_DRAIN; tick_in = '0;
                  end
               end
               PH_NUMBER: begin
                  hnum_in = line_byte; phase_in = PH_COMPLEMENT; tick_in = '0;
               end
               PH_COMPLEMENT: begin
                  if ({1'b0, hnum_ff} + {1'b0, line_byte} == {1'b0, mask}) begin
                     phase_in = PH_DATA; tick_in = '0; bcnt_in = '0;
                     crc_in = '0; sum_in = '0;
                     pass_in = (hnum_ff == ((expn_ff + 8'd1) & mask));
                  end else begin
                     if (pass_ff && bcnt_ff != 11'd0) begin
                        e.count = 2'd1; e.r0.block_discard = 1'b1;
                     end
                     pass_in = 1'b0; lcan_in = 1'b0; phase_in = PH_DRAIN; tick_in = '0;
                  end
               end
               PH_DATA: begin
                  tick_in = '0; crc_in = crc_nx; sum_in = sum_ff + line_byte;
                  bcnt_in = bcnt_nx;
                  if (pass_ff) begin
                     e.count = 2'd1; e.r0.data_valid = 1'b1; e.r0.data_byte = line_byte;
                  end
                  if (long_ff ? (bcnt_nx >= 11'(LONG_BLOCK_BYTES))
                              : (bcnt_nx >= 11'(SHORT_BLOCK_BYTES)))
                     phase_in = PH_CHECK_A;
               end
               PH_CHECK_A, PH_CHECK_B: begin
                  logic good;
                  good = 1'b0;
                  if (phase_ff == PH_CHECK_A) tick_in = '0;
                  if (phase_ff == PH_CHECK_A && crcchk_ff) begin
                     crc_in = crc_nx; phase_in = PH_CHECK_B;
                  end else begin
                     if (phase_ff == PH_CHECK_B) begin
                        crc_in = crc_nx;
                        good = (crc_nx == 16'd0);
                     end else begin
                        good = (((sum_ff - line_byte) & mask) == 8'd0);
                     end
                     if (good) begin
                        first_in = 1'b0;
                        if (pass_ff || hnum_ff == (expn_ff & mask)) begin
                           if (pass_ff) expn_in = expn_ff + 8'd1;
                           reply_in = CH_ACK;
                           ecnt_in = '0; lcan_in = 1'b0; pass_in = 1'b0;
                           wlim_in = (expn_in[6:0] != 7'd0) ? LATER_WAIT : FIRST_WAIT;
                           e.count = 2'd1;
                           e.r0.send_valid = 1'b1; e.r0.send_char = CH_ACK;
                           e.r0.block_commit = pass_ff;
                           phase_in = PH_HEADER; tick_in = '0;
                        end else begin
                           e.count = 2'd1; e.status = ST_SYNC;
                           phase_in = PH_IDLE; pass_in = 1'b0;
                        end
                     end else begin
                        if (pass_ff && bcnt_ff != 11'd0) begin
                           e.count = 2'd1; e.r0.block_discard = 1'b1;
                        end
                        pass_in = 1'b0; lcan_in = 1'b0; phase_in = PH_DRAIN; tick_in = '0;
                     end
                  end
               end
               PH_EOT: begin
                  if (pass_ff && bcnt_ff != 11'd0) begin
                     e.count = 2'd1; e.r0.block_discard = 1'b1;
                  end
                  pass_in = 1'b0; lcan_in = 1'b0; phase_in = PH_DRAIN; tick_in = '0;
               end
               PH_DRAIN: tick_in = '0;
               default: ;
            endcase
         end
         CMD_TICK: begin
            if (phase_ff != PH_IDLE) begin
               if (phase_ff == PH_HEADER)
                  lim = (wlim_ff == 8'd0) ? 8'd1 : wlim_ff;
               else if (phase_ff == PH_EOT || phase_ff == PH_DRAIN)
                  lim = QUIET_WAIT;
               tick_in = tick_nx;
               if (tick_nx >= lim) begin
                  tick_in = '0;
                  if (phase_ff == PH_EOT) begin
                     e.count = 2'd1; e.status = ST_DONE;
                     e.r0.send_valid = 1'b1; e.r0.send_char = CH_ACK;
                     phase_in = PH_IDLE; pass_in = 1'b0;
                  end else if (phase_ff == PH_DRAIN) begin
                     if (first_ff) begin
                        reply_in = crcchk_ff ? CH_WANT_CRC : CH_NAK;
                     end else begin
                        wlim_in = RETRY_WAIT; reply_in = CH_NAK;
                     end
                     ecnt_in = ecnt_nx;
                     if (ecnt_nx >= rlim) begin
                        e.can_burst = 1'b1; e.status = ST_RETRY;
                        phase_in = PH_IDLE; pass_in = 1'b0;
                     end else begin
                        e.count = 2'd1;
                        e.r0.send_valid = 1'b1; e.r0.send_char = reply_in;
                        phase_in = PH_HEADER;
                     end
                  end else begin
                     if (pass_ff && bcnt_ff != 11'd0) begin
                        e.count = 2'd1; e.r0.block_discard = 1'b1;
                     end
                     pass_in = 1'b0; lcan_in = 1'b0; phase_in = PH_DRAIN;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   assign ent       = e;
   assign ent_valid = fire && (e.count != 2'd0 || e.can_burst);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; long_ff <= 1'b0; hnum_ff <= '0; bcnt_ff <= '0;
         crc_ff <= '0; sum_ff <= '0; expn_ff <= '0; lcan_ff <= 1'b0;
         ecnt_ff <= '0; first_ff <= 1'b1; tick_ff <= '0; wlim_ff <= FIRST_WAIT;
         reply_ff <= CH_NAK; crcchk_ff <= 1'b1; pass_ff <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in; long_ff <= long_in; hnum_ff <= hnum_in;
         bcnt_ff <= bcnt_in; crc_ff <= crc_in; sum_ff <= sum_in; expn_ff <= expn_in;
         lcan_ff <= lcan_in; ecnt_ff <= ecnt_in; first_ff <= first_in;
         tick_ff <= tick_in; wlim_ff <= wlim_in; reply_ff <= reply_in;
         crcchk_ff <= crcchk_in; pass_ff <= pass_in;
      end
   end

endmodule

[rtl/core/xbr_queue.sv]
// ----------------------------------------------------------------------------
// XMODEM receiver entry queue
// Short FIFO between the protocol front end and the result sequencer.
// ----------------------------------------------------------------------------
module xbr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_valid,
   input  xbr_pkg::entry_type  wr_data,
   output logic                wr_ready,
   output logic                rd_valid,
   output xbr_pkg::entry_type  rd_data,
   input  logic                rd_ready
);
   import xbr_pkg::*;

   entry_type           mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wp_ff, rp_ff;
   logic [QUEUE_AW:0]   cnt_ff;
   logic                do_wr, do_rd;

   assign wr_ready = (cnt_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem_ff[rp_ff];
   assign do_wr    = wr_valid & wr_ready;
   assign do_rd    = rd_valid & rd_ready;

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (do_wr) wp_ff <= wp_ff + 1'b1;
         if (do_rd) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (QUEUE_AW+1)'(do_wr) - (QUEUE_AW+1)'(do_rd);
      end
   end

endmodule

[rtl/core/xbr_back.sv]
// ----------------------------------------------------------------------------
// XMODEM receiver result sequencer
// Expands queue entries into single result items with status and last.
// ----------------------------------------------------------------------------
module xbr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                ent_valid,
   input  xbr_pkg::entry_type  ent,
   output logic                ent_ready,
   output logic                out_valid,
   output xbr_pkg::result_type out_res,
   output logic [2:0]          out_status,
   output logic                out_last,
   input  logic                out_ready
);
   import xbr_pkg::*;

   logic [3:0] idx_ff;
   logic [3:0] total;
   logic       fin;

   assign total     = ent.can_burst ? CAN_BURST : {2'b00, ent.count};
   assign out_valid = ent_valid;
   assign out_last  = (idx_ff == total - 4'd1);
   assign out_status = ent.status;
   assign fin       = out_valid & out_ready & out_last;
   assign ent_ready = fin;

   always_comb begin
      out_res = '0;
      if (ent.can_burst) begin
         out_res.send_valid = 1'b1; out_res.send_char = CH_CAN;
      end else if (idx_ff == 4'd0) begin
         out_res = ent.r0;
      end else begin
         out_res = ent.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (out_valid & out_ready) begin
         idx_ff <= out_last ? 4'd0 : idx_ff + 4'd1;
      end
   end

endmodule
